/* hdl/lfu_pkg.sv */
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_COUNT_BITS = 16;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 5;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_W    = 64;
  localparam int OUT_W   = 40;
  localparam int OUT_PAD = OUT_W - (2 + VAL_W);

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } req_t;

  typedef struct packed {
    logic load_req;
    logic rd_en;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

/* hdl/lfu_cache_table_core.sv */
`timescale 1ns / 1ps
// Steps per request: the idle state takes it, a scan reads the single entry memory port once
// per slot, a drain state compares the last entry read, and a write-back state writes the entry
// and the result; the next request is taken only after that write-back.
// A finished result waits in an output register while the next request is taken; a result
// still waiting there at write-back holds that write-back until it is taken.
// Reset (rst, synchronous): entries invalid, occupancy and stamp counter zero, capacity 16.

module lfu_cache_table_core import lfu_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,   // capacity
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,    // key [31:0], value [63:32]
  input  logic             s_tuser,    // req_type
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata     // hit [0], read_value [32:1], evicted [33], zero
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  cmd_t             cmd;
  status_t          stat;
  logic [IDX_W-1:0] rd_addr;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;
  logic             out_evicted;

  assign cfg_ready = !rst;

  lfu_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  lfu_dp #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .stat           (stat),
    .in_req_type    (s_tuser),
    .in_key         (s_tdata[KEY_W-1:0]),
    .in_value       (s_tdata[KEY_W+VAL_W-1:KEY_W]),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

  assign m_tdata = {{OUT_PAD{1'b0}}, out_evicted, out_read_value, out_hit};

endmodule

/* hdl/lfu_ctrl.sv */
`timescale 1ns / 1ps

module lfu_ctrl import lfu_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  status_t          stat,
  output cmd_t             cmd,
  output logic [IDX_W-1:0] rd_addr
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] addr, addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

  always_comb begin
    state_next = state;
    addr_next  = addr;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_req = 1'b1;
          addr_next    = '0;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (addr == LAST_IDX) begin
          state_next = ST_DRAIN;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      // The last entry read is still being compared in this cycle.
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = addr;

endmodule

/* hdl/lfu_dp.sv */
`timescale 1ns / 1ps

module lfu_dp import lfu_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [IDX_W-1:0] rd_addr,
  output status_t          stat,
  input  logic             in_req_type,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_value,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_hit,
  output logic [VAL_W-1:0] out_read_value,
  output logic             out_evicted
);

  localparam int OCC_W   = $clog2(CAPACITY + 1);
  localparam int WORD_W  = KEY_W + VAL_W + COUNT_BITS + STAMP_W;
  localparam int VAL_LO  = KEY_W;
  localparam int CNT_LO  = KEY_W + VAL_W;
  localparam int STP_LO  = KEY_W + VAL_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // Entry storage: {stamp, count, value, key} per slot.
  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rd_word;
  logic [CAPACITY-1:0] valid;

  logic [CFG_W-1:0]   capacity;
  logic               req_put;
  logic [KEY_W-1:0]   req_key;
  logic [VAL_W-1:0]   req_value;
  logic               cmp_en;
  logic [IDX_W-1:0]   cmp_idx;

  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic [VAL_W-1:0]   match_value;
  logic [COUNT_BITS-1:0] match_count;
  logic               vic_found;
  logic [IDX_W-1:0]   vic_idx;
  logic [COUNT_BITS-1:0] vic_count;
  logic [STAMP_W-1:0] vic_stamp;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  logic [OCC_W-1:0]   occupancy;
  logic [STAMP_W-1:0] stamp_counter;

  logic [KEY_W-1:0]      rd_key;
  logic [VAL_W-1:0]      rd_value;
  logic [COUNT_BITS-1:0] rd_count;
  logic [STAMP_W-1:0]    rd_stamp;
  logic                  e_valid;

  logic [OCC_W-1:0]      eff_cap;
  logic [STAMP_W-1:0]    stamp_plus;
  logic [COUNT_BITS-1:0] count_sat;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [VAL_W-1:0]      wr_value;
  logic [COUNT_BITS-1:0] wr_count;
  logic                  set_valid;
  logic                  res_hit;
  logic [VAL_W-1:0]      res_value;
  logic                  res_evicted;

  assign rd_key   = rd_word[KEY_W-1:0];
  assign rd_value = rd_word[CNT_LO-1:VAL_LO];
  assign rd_count = rd_word[STP_LO-1:CNT_LO];
  assign rd_stamp = rd_word[WORD_W-1:STP_LO];
  assign e_valid  = valid[cmp_idx];

  assign eff_cap    = (int'(capacity) > CAPACITY) ? OCC_W'(CAPACITY) : OCC_W'(capacity);
  assign stamp_plus = stamp_counter + 1'b1;
  assign count_sat  = (match_count == '1) ? match_count : match_count + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_word <= mem[rd_addr];
    end
    if (cmd.update && wr_en) begin
      mem[wr_idx] <= {stamp_plus, wr_count, wr_value, req_key};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_put   <= in_req_type;
      req_key   <= in_key;
      req_value <= in_value;
    end
    cmp_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // One stored entry is compared per cycle, in the cycle after its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en      <= 1'b0;
      match_found <= 1'b0;
      vic_found   <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      cmp_en <= cmd.rd_en;
      if (cmd.load_req) begin
        match_found <= 1'b0;
        vic_found   <= 1'b0;
        free_found  <= 1'b0;
      end else if (cmp_en) begin
        if (e_valid && !match_found && rd_key == req_key) begin
          match_found <= 1'b1;
          match_idx   <= cmp_idx;
          match_value <= rd_value;
          match_count <= rd_count;
        end
        if (e_valid && (!vic_found || rd_count < vic_count ||
                        (rd_count == vic_count && rd_stamp < vic_stamp))) begin
          vic_found <= 1'b1;
          vic_idx   <= cmp_idx;
          vic_count <= rd_count;
          vic_stamp <= rd_stamp;
        end
        if (!e_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = match_idx;
    wr_value    = req_value;
    wr_count    = count_sat;
    set_valid   = 1'b0;
    res_hit     = match_found;
    res_value   = '0;
    res_evicted = 1'b0;
    if (req_put == REQ_GET) begin
      if (match_found) begin
        wr_en     = 1'b1;
        wr_value  = match_value;
        res_value = match_value;
      end
    end else if (eff_cap != '0) begin
      if (match_found) begin
        wr_en = 1'b1;
      end else if (occupancy >= eff_cap && vic_found) begin
        // Full: the new entry takes over the victim's slot.
        wr_en       = 1'b1;
        wr_idx      = vic_idx;
        wr_count    = CNT_ONE;
        res_evicted = 1'b1;
      end else if (free_found) begin
        wr_en     = 1'b1;
        wr_idx    = free_idx;
        wr_count  = CNT_ONE;
        set_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      occupancy     <= '0;
      stamp_counter <= '0;
    end else if (cmd.update && wr_en) begin
      stamp_counter <= stamp_plus;
      if (set_valid) begin
        valid[wr_idx] <= 1'b1;
        occupancy     <= occupancy + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit        <= res_hit;
      out_read_value <= res_value;
      out_evicted    <= res_evicted;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

/* hdl/lfu_checker.sv */
`timescale 1ns / 1ps

module lfu_checker import lfu_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // A request is worked on alone: no second transaction right after one is taken.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on two consecutive cycles");

  // An eviction only happens for a put to an absent key.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
    else $error("result reports both hit and eviction");

  // Without a hit there is no value to return.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == '0)
    else $error("read value nonzero on a miss");

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind lfu_cache_table_core lfu_checker u_lfu_checker (.*);
